/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
// All checks sample on the rising edge of clk and hold off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* hw/rtl/pmorph_pkg.sv */
package pmorph_pkg;

  // Request kinds carried on in_tuser
  typedef enum logic [1:0] {
    CMD_WR_CUR = 2'd0,
    CMD_WR_TGT = 2'd1,
    CMD_MORPH  = 2'd2,
    CMD_TICK   = 2'd3
  } pmorph_cmd_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PARAM_COUNT     = 2'd0,
    CFG_VEL_DEST_BASE   = 2'd1,
    CFG_LFO_VOICE_BASE  = 2'd2,
    CFG_LFO_TARGET_BASE = 2'd3
  } pmorph_cfg_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } pmorph_state_t;

  // Controller address that travels with a slot through the blend pipeline
  typedef struct packed {
    logic       bank;
    logic [6:0] number;
  } pmorph_tag_t;

  localparam logic [8:0] PARAM_COUNT_RST = 9'd256;
  localparam logic [8:0] AMT_FULL        = 9'd256;
  localparam logic [7:0] ROUND_THRESH    = 8'h7f;
  localparam logic [8:0] SKIP_SLOT       = 9'd127;
  localparam logic [8:0] BANK_SPLIT      = 9'd128;
  localparam logic [8:0] SKIP_SPAN       = 9'd5;

endpackage

/* hw/rtl/pmorph_blend.sv */
module pmorph_blend
  import pmorph_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_v,
  input  pmorph_tag_t in_tag,
  input  logic [7:0]  cur,
  input  logic [7:0]  tgt,
  input  logic [7:0]  amt,
  output logic        out_v,
  output pmorph_tag_t out_tag,
  output logic [7:0]  out_val
);

  logic        a_v_r;
  pmorph_tag_t a_tag_r;
  logic [16:0] prod_c_r;
  logic [15:0] prod_t_r;
  logic        b_v_r;
  pmorph_tag_t b_tag_r;
  logic [7:0]  b_val_r;

  logic [8:0]  inv_amt;
  logic [16:0] prod_c_nxt;
  logic [15:0] prod_t_nxt;
  logic [16:0] sum_wide;
  logic [15:0] sum16;
  logic [7:0]  val_nxt;

  // Stage A: weight current and target values
  assign inv_amt    = AMT_FULL - {1'b0, amt};
  assign prod_c_nxt = {9'd0, cur} * {8'd0, inv_amt};
  assign prod_t_nxt = {8'd0, tgt} * {8'd0, amt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_tag_r  <= in_tag;
      prod_c_r <= prod_c_nxt;
      prod_t_r <= prod_t_nxt;
    end
  end

  // Stage B: add modulo 2^16, keep the high byte, round up on a large low byte
  assign sum_wide = prod_c_r + {1'b0, prod_t_r};
  assign sum16    = sum_wide[15:0];
  assign val_nxt  = sum16[15:8] + {7'd0, (sum16[7:0] >= ROUND_THRESH)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_tag_r <= a_tag_r;
      b_val_r <= val_nxt;
    end
  end

  assign out_v   = b_v_r;
  assign out_tag = b_tag_r;
  assign out_val = b_val_r;

endmodule

/* hw/rtl/parameter_morph_sequencer_core.sv */
// Channel  Dir  Ports                       Contents
// in       in   in_tvalid/in_tready         tuser: cmd; tdata: slot, data
// out      out  out_tvalid/out_tready       tuser: bank; tdata: number, blended
// cfg      in   cfg_we/cfg_index/cfg_wdata  register index and value, no handshake
//
// One request is taken per cycle whenever the output register is free or being drained.
// A tick that sends a slot reaches out_tvalid through the memory read at its accepting edge,
// the multiply stage, and the add and round stage into the output register.
// A stalled output freezes the whole pipeline and holds in_tready low.
// Reset is synchronous (rst_n low); the parameter memories are not cleared.
`include "assert_macros.svh"

module parameter_morph_sequencer_core
  import pmorph_pkg::*;
#(
  parameter int MAX_PARAMS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  input  logic [15:0] in_tdata,   // [7:0] slot, [15:8] data
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,  // [0] bank
  output logic [15:0] out_tdata,  // [6:0] number, [14:7] blended, [15] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_wdata
);

  localparam int AW = $clog2(MAX_PARAMS);
  localparam int CW = $clog2(MAX_PARAMS + 1);
  localparam logic [8:0] MAX_P = 9'(MAX_PARAMS);

  // Configuration registers
  logic [8:0] param_count_r;
  logic [7:0] vel_base_r;
  logic [7:0] lfo_voice_base_r;
  logic [7:0] lfo_tgt_base_r;

  // Control state
  pmorph_state_t st_r, st_nxt;
  logic [7:0]    wanted_amt_r, wanted_amt_nxt;
  logic [7:0]    pass_amt_r, pass_amt_nxt;
  logic [15:0]   req_cnt_r, req_cnt_nxt;
  logic [15:0]   pass_cnt_r, pass_cnt_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;

  // Memories and read stage
  logic [7:0]  cur_mem [MAX_PARAMS];
  logic [7:0]  tgt_mem [MAX_PARAMS];
  logic [7:0]  cur_rd_r;
  logic [7:0]  tgt_rd_r;
  logic        s1_v_r;
  pmorph_tag_t s1_tag_r;
  logic [7:0]  s1_amt_r;

  logic        en;
  logic        in_acc;
  pmorph_cmd_t cmd;
  logic [7:0]  in_slot;
  logic [7:0]  in_data;
  logic        slot_ok;
  logic [8:0]  idx9;
  logic [8:0]  limit;
  logic        at_end;
  logic        skip_hit;
  logic        emit;
  pmorph_tag_t idx_tag;
  pmorph_tag_t res_tag;
  logic [7:0]  res_val;
  logic        res_v;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign in_acc    = in_tvalid && in_tready;
  assign cmd       = pmorph_cmd_t'(in_tuser);
  assign in_slot   = in_tdata[7:0];
  assign in_data   = in_tdata[15:8];
  assign slot_ok   = {1'b0, in_slot} < MAX_P;

  // Slot walk decode
  assign idx9   = 9'(cursor_r);
  assign limit  = (param_count_r > MAX_P) ? MAX_P : param_count_r;
  assign at_end = idx9 >= limit;

  assign skip_hit = (idx9 == SKIP_SLOT) ||
                    ((idx9 >= {1'b0, vel_base_r}) &&
                     (idx9 <= ({1'b0, vel_base_r} + SKIP_SPAN))) ||
                    ((idx9 >= {1'b0, lfo_voice_base_r}) &&
                     (idx9 <= ({1'b0, lfo_voice_base_r} + SKIP_SPAN))) ||
                    ((idx9 >= {1'b0, lfo_tgt_base_r}) &&
                     (idx9 <= ({1'b0, lfo_tgt_base_r} + SKIP_SPAN)));

  assign idx_tag.bank   = idx9 >= BANK_SPLIT;
  assign idx_tag.number = idx9[6:0];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      param_count_r    <= PARAM_COUNT_RST;
      vel_base_r       <= 8'd0;
      lfo_voice_base_r <= 8'd0;
      lfo_tgt_base_r   <= 8'd0;
    end else if (cfg_we) begin
      unique case (pmorph_cfg_t'(cfg_index))
        CFG_PARAM_COUNT:     param_count_r    <= cfg_wdata;
        CFG_VEL_DEST_BASE:   vel_base_r       <= cfg_wdata[7:0];
        CFG_LFO_VOICE_BASE:  lfo_voice_base_r <= cfg_wdata[7:0];
        CFG_LFO_TARGET_BASE: lfo_tgt_base_r   <= cfg_wdata[7:0];
      endcase
    end
  end

  // Next state: morph requests and ticks
  always_comb begin
    st_nxt         = st_r;
    wanted_amt_nxt = wanted_amt_r;
    pass_amt_nxt   = pass_amt_r;
    req_cnt_nxt    = req_cnt_r;
    pass_cnt_nxt   = pass_cnt_r;
    cursor_nxt     = cursor_r;
    emit           = 1'b0;
    if (in_acc) begin
      unique case (cmd)
        CMD_MORPH: begin
          if ((wanted_amt_r != in_data) || (st_r == ST_IDLE)) begin
            req_cnt_nxt = req_cnt_r + 16'd1;
          end
          wanted_amt_nxt = in_data;
          if (st_r == ST_IDLE) begin
            st_nxt       = ST_RUN;
            pass_amt_nxt = in_data;
            pass_cnt_nxt = req_cnt_nxt;
            cursor_nxt   = '0;
          end
        end
        CMD_TICK: begin
          if (st_r == ST_RUN) begin
            if (at_end) begin
              if (pass_cnt_r != req_cnt_r) begin
                pass_amt_nxt = wanted_amt_r;
                pass_cnt_nxt = req_cnt_r;
                cursor_nxt   = '0;
              end else begin
                st_nxt = ST_IDLE;
              end
            end else begin
              cursor_nxt = cursor_r + CW'(1);
              emit       = !skip_hit;
            end
          end
        end
        CMD_WR_CUR, CMD_WR_TGT: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      wanted_amt_r <= 8'd0;
      pass_amt_r   <= 8'd0;
      req_cnt_r    <= 16'd0;
      pass_cnt_r   <= 16'd0;
      cursor_r     <= '0;
    end else begin
      st_r         <= st_nxt;
      wanted_amt_r <= wanted_amt_nxt;
      pass_amt_r   <= pass_amt_nxt;
      req_cnt_r    <= req_cnt_nxt;
      pass_cnt_r   <= pass_cnt_nxt;
      cursor_r     <= cursor_nxt;
    end
  end

  // Parameter memories: write on accepted write requests to a slot below MAX_PARAMS, read the cursor slot.
  // A write lands at its accept edge, so a later tick always sees it.
  always_ff @(posedge clk) begin
    if (in_acc && (cmd == CMD_WR_CUR) && slot_ok) begin
      cur_mem[in_slot[AW-1:0]] <= in_data;
    end
    if (en) begin
      cur_rd_r <= cur_mem[cursor_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (cmd == CMD_WR_TGT) && slot_ok) begin
      tgt_mem[in_slot[AW-1:0]] <= in_data;
    end
    if (en) begin
      tgt_rd_r <= tgt_mem[cursor_r[AW-1:0]];
    end
  end

  // Read stage sideband
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag_r <= idx_tag;
      s1_amt_r <= pass_amt_r;
    end
  end

  pmorph_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (s1_v_r),
    .in_tag  (s1_tag_r),
    .cur     (cur_rd_r),
    .tgt     (tgt_rd_r),
    .amt     (s1_amt_r),
    .out_v   (res_v),
    .out_tag (res_tag),
    .out_val (res_val)
  );

  assign out_tvalid = res_v;
  assign out_tuser  = res_tag.bank;
  assign out_tdata  = {1'b0, res_val, res_tag.number};

  // Checks
  `ASSERT_NEXT(a_idle_no_emit, in_acc && (st_r == ST_IDLE), !s1_v_r)
  `ASSERT_NEXT(a_skip_no_emit,
               in_acc && (cmd == CMD_TICK) && (st_r == ST_RUN) && !at_end && skip_hit,
               !s1_v_r)
  `ASSERT_NEXT(a_restart_sync,
               in_acc && (cmd == CMD_TICK) && (st_r == ST_RUN) && at_end &&
               (pass_cnt_r != req_cnt_r),
               (pass_cnt_r == req_cnt_r) && (st_r == ST_RUN) && (cursor_r == '0))

endmodule
